FILE: hw/rtl/pswrl_pkg.sv
// Package for the per-source window rate limiter: op codes, field widths
// and the word that travels along the rule cell chain.
// No dependencies.
package pswrl_pkg;

    localparam int SLOT_W = 6;
    localparam int IP_W   = 32;
    localparam int CNT_W  = 32;
    localparam int LEN_W  = 16;

    typedef enum logic {
        OP_INSTALL = 1'b0,
        OP_CHECK   = 1'b1
    } op_t;

    // One command word and its partial result as it moves down the chain.
    typedef struct packed {
        logic              vld;
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [IP_W-1:0]   pod_ip;
        logic              enable;
        logic [CNT_W-1:0]  byte_limit;
        logic [CNT_W-1:0]  packet_limit;
        logic [LEN_W-1:0]  packet_length;
        logic [CNT_W-1:0]  now_sec;
        logic              claimed;
        logic              drop;
        logic              matched;
    } tok_t;

endpackage

FILE: hw/rtl/pswrl_cell.sv
// One rule cell: holds a single slot's rule and window counters, acts on the
// word passing through and hands it on, registered, to the next cell.
// Depends on pswrl_pkg.
module pswrl_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pswrl_pkg::tok_t tok_in,
    output pswrl_pkg::tok_t tok_out
);
    import pswrl_pkg::*;

    localparam bit                REACHABLE = (IDX < (1 << SLOT_W));
    localparam logic [SLOT_W-1:0] MY_SLOT   = SLOT_W'(IDX);

    logic             valid_reg,  valid_next;
    logic [IP_W-1:0]  key_reg,    key_next;
    logic             en_reg,     en_next;
    logic [CNT_W-1:0] blim_reg,   blim_next;
    logic [CNT_W-1:0] plim_reg,   plim_next;
    logic [CNT_W-1:0] wsec_reg,   wsec_next;
    logic [CNT_W-1:0] wbytes_reg, wbytes_next;
    logic [CNT_W-1:0] wpkts_reg,  wpkts_next;
    tok_t             tok_reg,    tok_next;

    logic             wr_hit;
    logic             chk_hit;
    logic             new_win;
    logic [CNT_W-1:0] eff_bytes;
    logic [CNT_W-1:0] eff_pkts;
    logic [CNT_W:0]   byte_sum;
    logic [CNT_W:0]   pkt_sum;
    logic             byte_over;
    logic             pkt_over;
    logic             over;

    assign wr_hit  = tok_in.vld && (tok_in.op == OP_INSTALL) && REACHABLE
                     && (tok_in.slot == MY_SLOT);
    assign chk_hit = tok_in.vld && (tok_in.op == OP_CHECK) && !tok_in.claimed
                     && valid_reg && (key_reg == tok_in.pod_ip);

    // a later second opens a fresh window
    assign new_win   = tok_in.now_sec > wsec_reg;
    assign eff_bytes = new_win ? '0 : wbytes_reg;
    assign eff_pkts  = new_win ? '0 : wpkts_reg;
    assign byte_sum  = {1'b0, eff_bytes} + {{(CNT_W + 1 - LEN_W){1'b0}}, tok_in.packet_length};
    assign pkt_sum   = {1'b0, eff_pkts} + {{CNT_W{1'b0}}, 1'b1};
    assign byte_over = (blim_reg != '0) && (byte_sum > {1'b0, blim_reg});
    assign pkt_over  = (plim_reg != '0) && (pkt_sum > {1'b0, plim_reg});
    assign over      = byte_over || pkt_over;

    always_comb
    begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        en_next     = en_reg;
        blim_next   = blim_reg;
        plim_next   = plim_reg;
        wsec_next   = wsec_reg;
        wbytes_next = wbytes_reg;
        wpkts_next  = wpkts_reg;
        tok_next    = tok_in;
        if (wr_hit)
        begin
            valid_next  = 1'b1;
            key_next    = tok_in.pod_ip;
            en_next     = tok_in.enable;
            blim_next   = tok_in.byte_limit;
            plim_next   = tok_in.packet_limit;
            wsec_next   = '0;
            wbytes_next = '0;
            wpkts_next  = '0;
        end
        else if (chk_hit)
        begin
            // lowest matching slot claims the word, even when disabled
            tok_next.claimed = 1'b1;
            tok_next.matched = en_reg;
            tok_next.drop    = en_reg && over;
            if (en_reg)
            begin
                wsec_next = new_win ? tok_in.now_sec : wsec_reg;
                if (over)
                begin
                    wbytes_next = eff_bytes;
                    wpkts_next  = eff_pkts;
                end
                else
                begin
                    wbytes_next = byte_sum[CNT_W] ? '1 : byte_sum[CNT_W-1:0];
                    wpkts_next  = pkt_sum[CNT_W] ? '1 : pkt_sum[CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        en_reg     <= en_next;
        blim_reg   <= blim_next;
        plim_reg   <= plim_next;
        wsec_reg   <= wsec_next;
        wbytes_reg <= wbytes_next;
        wpkts_reg  <= wpkts_next;
    end

    assign tok_out = tok_reg;

endmodule

FILE: hw/rtl/per_source_window_rate_limiter.sv
// Results: each accepted word passes through the registers of the rule cells in
// chain order and its result is shown with done; it is on the ports for one cycle.
// Throughput: one word per cycle; each rule cell in the chain registers the word.
// Reset: asynchronous, active low; clears all rule valid bits and the chain.
// The receiver cannot stall: busy stays low and results are never held.
module per_source_window_rate_limiter #(
    parameter int RULE_SLOTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        op,
    input  logic [pswrl_pkg::SLOT_W-1:0] slot,
    input  logic [pswrl_pkg::IP_W-1:0]  pod_ip,
    input  logic                        enable,
    input  logic [pswrl_pkg::CNT_W-1:0] byte_limit,
    input  logic [pswrl_pkg::CNT_W-1:0] packet_limit,
    input  logic [pswrl_pkg::LEN_W-1:0] packet_length,
    input  logic [pswrl_pkg::CNT_W-1:0] now_sec,
    output logic                        done,
    output logic                        drop,
    output logic                        matched
);
    import pswrl_pkg::*;

    tok_t chain [RULE_SLOTS+1];

    // the chain takes a new word every cycle
    assign busy = 1'b0;

    assign chain[0] = '{
        vld:           start && !busy,
        op:            op_t'(op),
        slot:          slot,
        pod_ip:        pod_ip,
        enable:        enable,
        byte_limit:    byte_limit,
        packet_limit:  packet_limit,
        packet_length: packet_length,
        now_sec:       now_sec,
        claimed:       1'b0,
        drop:          1'b0,
        matched:       1'b0
    };

    for (genvar i = 0; i < RULE_SLOTS; i++)
    begin : g_cell
        pswrl_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign done    = chain[RULE_SLOTS].vld;
    assign drop    = chain[RULE_SLOTS].drop;
    assign matched = chain[RULE_SLOTS].matched;

endmodule

FILE: hw/rtl/pswrl_checker.sv
// Port-level checker for the rate limiter, bound to the top level.
// Depends on pswrl_pkg and per_source_window_rate_limiter.
module pswrl_checker #(
    parameter int RULE_SLOTS = 64
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic op,
    input logic done,
    input logic drop,
    input logic matched
);
    import pswrl_pkg::*;

    localparam int LAT   = RULE_SLOTS;
    localparam int WARM_W = $clog2(RULE_SLOTS + 2);

    logic              accept;
    logic [WARM_W-1:0] warm_reg, warm_next;
    logic              warm;

    assign accept = start && !busy;
    assign warm   = (warm_reg == WARM_W'(LAT));

    // count cycles since reset until the chain holds only post-reset words
    assign warm_next = warm ? warm_reg : warm_reg + WARM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
        end
        else
        begin
            warm_reg <= warm_next;
        end
    end

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("accepted word gave no result");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && warm) |-> $past(accept, LAT))
        else $error("result without an accepted word");

    a_drop_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (matched || !drop))
        else $error("drop without a matched rule");

    a_install_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && warm && $past(accept && (op == OP_INSTALL), LAT)) |->
        (!drop && !matched))
        else $error("install word reported drop or match");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind per_source_window_rate_limiter pswrl_checker #(
    .RULE_SLOTS (RULE_SLOTS)
) u_pswrl_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .op      (op),
    .done    (done),
    .drop    (drop),
    .matched (matched)
);
